### src/mtdsf_pkg.sv
package mtdsf_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SIXTEEN_BIT_MODE = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd1;
  localparam logic [1:0] REG_RING_LENGTH      = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Register reset values
  localparam logic        SIXTEEN_BIT_RESET   = 1'b1;
  localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd2;
  localparam logic [16:0] RING_LENGTH_RESET   = 17'd16384;

  // Ring limits (slot_index is 16 bits, so the ring never exceeds 65536)
  localparam logic [16:0] MAX_RING_SLOTS = 17'd65536;

  localparam int DEF_MAX_OUT_CHANNELS = 8;

  // Clamp limits of a 16-bit sample
  localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;
  localparam logic [7:0]  BYTE_BIAS  = 8'h80;

  typedef logic [15:0] sample_t;

  // Floor of x/256, clamped to the signed 16-bit range
  function automatic sample_t scale_and_clamp(input logic [31:0] raw);
    logic [23:0] s;
    sample_t     v;
    s = raw[31:8];
    if (s[23:15] == 9'h000 || s[23:15] == 9'h1ff) begin
      v = s[15:0];
    end else if (s[23]) begin
      v = SAMPLE_MIN;
    end else begin
      v = SAMPLE_MAX;
    end
    return v;
  endfunction

endpackage

### src/mix_to_dma_sample_formatter.sv
// A frame passes through the frame register and then the output register before its first slot
// is presented; later slots follow one per cycle unless the sink holds out_ready low, and a new
// frame is taken as the last slot of the current one is emitted through the single slot-emit path.
// Reset (rst, synchronous): registers return to 16-bit mode, 2 channels, 16384 slots;
// write position goes to 0 and both frame and output stages go empty.
module mix_to_dma_sample_formatter #(
  parameter int MAX_OUT_CHANNELS = mtdsf_pkg::DEF_MAX_OUT_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   left_mix,
  input  logic signed [31:0]                   right_mix,
  input  logic                                 end_of_block,
  // slot output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [15:0]                          sample_value,
  output logic [15:0]                          slot_index,
  output logic                                 last_of_frame,
  output logic                                 block_done,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mtdsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mtdsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtdsf_pkg::*;

  localparam int CNT_W = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int IDX_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int CMP_W = CNT_W + 4;

  // Configuration registers
  logic        sixteen_bit_mode;
  logic [3:0]  channel_count;
  logic [16:0] ring_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_bit_mode <= SIXTEEN_BIT_RESET;
      channel_count    <= CHANNEL_COUNT_RESET;
      ring_length      <= RING_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIXTEEN_BIT_MODE: sixteen_bit_mode <= cfg_data[0];
        REG_CHANNEL_COUNT:    channel_count    <= cfg_data[3:0];
        REG_RING_LENGTH:      ring_length      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Effective channel count and ring length
  logic [CNT_W-1:0] chans_eff;
  logic [16:0]      ring_eff;

  always_comb begin
    if (channel_count == 4'd0) begin
      chans_eff = CNT_W'(1);
    end else if (CMP_W'(channel_count) > CMP_W'(MAX_OUT_CHANNELS)) begin
      chans_eff = CNT_W'(MAX_OUT_CHANNELS);
    end else begin
      chans_eff = CNT_W'(channel_count);
    end
    if (ring_length == 17'd0) begin
      ring_eff = 17'd1;
    end else if (ring_length > MAX_RING_SLOTS) begin
      ring_eff = MAX_RING_SLOTS;
    end else begin
      ring_eff = ring_length;
    end
  end

  // Frame register: holds one frame while its slots go out
  logic             frame_valid;
  logic [31:0]      frame_left;
  logic [31:0]      frame_right;
  logic             frame_eob;
  logic [IDX_W-1:0] ch_idx;
  logic [15:0]      write_position;

  logic slot_fire;
  logic slot_last;

  assign slot_fire = frame_valid && (!out_valid || out_ready);
  assign slot_last = (CNT_W'(ch_idx) + CNT_W'(1)) == chans_eff;
  assign in_ready  = !frame_valid || (slot_fire && slot_last);

  // Slot value: pick channel, scale, clamp, format
  logic [31:0] raw_sel;
  sample_t     v_sel;
  logic [15:0] bits_sel;

  always_comb begin
    if (ch_idx == IDX_W'(0)) begin
      raw_sel = frame_left;
    end else if (ch_idx == IDX_W'(1)) begin
      raw_sel = frame_right;
    end else begin
      raw_sel = 32'd0;
    end
    v_sel = scale_and_clamp(raw_sel);
    if (sixteen_bit_mode) begin
      bits_sel = v_sel;
    end else begin
      bits_sel = {8'd0, v_sel[15:8] ^ BYTE_BIAS};
    end
  end

  // Ring position for this slot and the one after
  logic [15:0] pos_cur;
  logic [16:0] pos_inc;
  logic [15:0] write_position_next;

  always_comb begin
    pos_cur = ({1'b0, write_position} >= ring_eff) ? 16'd0 : write_position;
    pos_inc = {1'b0, pos_cur} + 17'd1;
    write_position_next = (pos_inc >= ring_eff) ? 16'd0 : pos_inc[15:0];
  end

  // Frame and channel control
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid    <= 1'b0;
      ch_idx         <= '0;
      write_position <= 16'd0;
    end else begin
      if (slot_fire) begin
        write_position <= write_position_next;
        ch_idx         <= slot_last ? '0 : ch_idx + IDX_W'(1);
      end
      if (in_valid && in_ready) begin
        frame_valid <= 1'b1;
      end else if (slot_fire && slot_last) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_left  <= left_mix;
      frame_right <= right_mix;
      frame_eob   <= end_of_block;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_fire) begin
      sample_value  <= bits_sel;
      slot_index    <= pos_cur;
      last_of_frame <= slot_last;
      block_done    <= slot_last && frame_eob;
    end
  end

`ifndef SYNTHESIS
  a_slot_in_ring: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, slot_index} < ring_eff))
    else $error("slot index outside ring");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_done) |-> last_of_frame)
    else $error("block_done without last_of_frame");

  a_idle_channel: assert property (@(posedge clk) disable iff (rst)
    !frame_valid |-> (ch_idx == '0))
    else $error("channel index not at zero while no frame held");

  a_frame_loaded: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> frame_valid)
    else $error("frame lost after transfer in");

  a_slot_follows: assert property (@(posedge clk) disable iff (rst)
    slot_fire |=> out_valid)
    else $error("emitted slot not presented");
`endif

endmodule

### tb/sv/mtdsf_slot_checker.sv
module mtdsf_slot_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [31:0]                          left_mix,
  input  logic [31:0]                          right_mix,
  input  logic                                 end_of_block,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [15:0]                          sample_value,
  input  logic [15:0]                          slot_index,
  input  logic                                 last_of_frame,
  input  logic                                 block_done,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mtdsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mtdsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   waiting,
  output int                                   slots_seen
);
  import mtdsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] slot;
    logic        last;
    logic        done;
  } slot_rec_t;

  // register shadows and ring position
  logic        sixteen_mode;
  logic [3:0]  chan_reg;
  logic [16:0] ring_reg;
  int          wpos;

  slot_rec_t   pending_slots[$];

  initial begin
    fail_count = 0;
    waiting    = 0;
    slots_seen = 0;
  end

  // floor(acc / 256), saturated to signed 16 bits
  function automatic logic signed [15:0] scale_acc(input logic signed [31:0] acc);
    logic signed [31:0] q;
    q = acc >>> 8;
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return 16'sh8000;
    return q[15:0];
  endfunction

  // expected slots of one frame, in channel order
  task automatic format_frame(input logic [31:0] l, input logic [31:0] r, input logic eob);
    int                 chans;
    int                 len;
    logic signed [15:0] lv;
    logic signed [15:0] rv;
    logic signed [15:0] v;
    slot_rec_t          rec;
    lv = scale_acc(l);
    rv = scale_acc(r);
    chans = (chan_reg == 0) ? 1 :
            (chan_reg > DEF_MAX_OUT_CHANNELS) ? DEF_MAX_OUT_CHANNELS : int'(chan_reg);
    len = (ring_reg == 0) ? 1 : (ring_reg > MAX_RING_SLOTS) ? int'(MAX_RING_SLOTS)
                                                             : int'(ring_reg);
    for (int c = 0; c < chans; c++) begin
      v = (c == 0) ? lv : (c == 1) ? rv : 16'sd0;
      // 8-bit slots: high byte with the sign flipped, i.e. (v>>8)+128
      rec.value = sixteen_mode ? v : {8'h00, ~v[15], v[14:8]};
      // ring may have shrunk below the current position
      if (wpos >= len) wpos = 0;
      rec.slot = wpos[15:0];
      rec.last = (c == chans - 1);
      rec.done = rec.last & eob;
      pending_slots.push_back(rec);
      wpos = (wpos + 1 >= len) ? 0 : wpos + 1;
    end
  endtask

  always @(posedge clk) begin
    slot_rec_t exp_rec;
    if (rst) begin
      sixteen_mode = SIXTEEN_BIT_RESET;
      chan_reg     = CHANNEL_COUNT_RESET;
      ring_reg     = RING_LENGTH_RESET;
      wpos         = 0;
      pending_slots.delete();
    end else begin
      // slot transfer out
      if (out_valid && out_ready) begin
        slots_seen++;
        if (pending_slots.size() == 0) begin
          $error("slot at index %h arrived with no frame pending", slot_index);
          fail_count++;
        end else begin
          exp_rec = pending_slots.pop_front();
          if (sample_value !== exp_rec.value) begin
            $error("sample_value: expected %h, got %h", exp_rec.value, sample_value);
            fail_count++;
          end
          if (slot_index !== exp_rec.slot) begin
            $error("slot_index: expected %h, got %h", exp_rec.slot, slot_index);
            fail_count++;
          end
          if (last_of_frame !== exp_rec.last) begin
            $error("last_of_frame: expected %b, got %b", exp_rec.last, last_of_frame);
            fail_count++;
          end
          if (block_done !== exp_rec.done) begin
            $error("block_done: expected %b, got %b", exp_rec.done, block_done);
            fail_count++;
          end
        end
      end
      // register writes, masked to width; unknown index dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIXTEEN_BIT_MODE: sixteen_mode = cfg_data[0];
          REG_CHANNEL_COUNT:    chan_reg     = cfg_data[3:0];
          REG_RING_LENGTH:      ring_reg     = cfg_data[16:0];
          default: ;
        endcase
      end
      // frame transfer in
      if (in_valid && in_ready) format_frame(left_mix, right_mix, end_of_block);
    end
    waiting = pending_slots.size();
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import mtdsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int TOTAL_FRAMES = 260;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [31:0]     left_mix = '0;
  logic signed [31:0]     right_mix = '0;
  logic                   end_of_block = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [15:0]            sample_value;
  logic [15:0]            slot_index;
  logic                   last_of_frame;
  logic                   block_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int waiting;
  int slots_seen;

  // no random stalls on either side while set
  logic calm = 1'b0;
  int   frames_sent = 0;
  int   settings_used = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mix_to_dma_sample_formatter dut (
    .clk, .rst,
    .in_valid, .in_ready, .left_mix, .right_mix, .end_of_block,
    .out_valid, .out_ready, .sample_value, .slot_index, .last_of_frame, .block_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mtdsf_slot_checker chk (
    .clk, .rst,
    .in_valid, .in_ready, .left_mix, .right_mix, .end_of_block,
    .out_valid, .out_ready, .sample_value, .slot_index, .last_of_frame, .block_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .waiting, .slots_seen
  );

  // one frame transfer; called and returns at a falling edge, valid left high
  task automatic send_frame(input logic [31:0] l, input logic [31:0] r, input logic eob);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    left_mix     = l;
    right_mix    = r;
    end_of_block = eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain all outstanding slots, then let the pipeline settle
  task automatic settle();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    settings_used++;
  endtask

  // accumulator values weighted toward the clamp edges
  function automatic logic [31:0] draw_mix();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000;
      1: return 32'h007f_ff00 + 32'($urandom_range(0, 511));
      2: return 32'hff7f_ff00 + 32'($urandom_range(0, 511));
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] d;
    // mode write with junk in the upper bits
    write_reg(REG_SIXTEEN_BIT_MODE, CFG_DATA_W'($urandom_range(0, 17'h1ffff)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: d = CFG_DATA_W'($urandom_range(1, 8));
      default: d = CFG_DATA_W'($urandom_range(0, 17'h1ffff));
    endcase
    write_reg(REG_CHANNEL_COUNT, d);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = CFG_DATA_W'($urandom_range(1, 40));
      6: d = CFG_DATA_W'($urandom_range(0, 17'h1ffff));
      7: d = MAX_RING_SLOTS;
      8: d = '0;
      default: d = CFG_DATA_W'($urandom_range(17'h10001, 17'h1ffff));
    endcase
    write_reg(REG_RING_LENGTH, d);
    if ($urandom_range(0, 4) == 0)
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 17'h1ffff)));
  endtask

  // sink side: random stall before each slot transfer
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    int phase_len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: 16-bit stereo, clamp edges both ways
    send_frame(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_frame(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_frame(32'h007f_ffff, 32'hff80_0000, 1'b0);
    send_frame(32'h0080_0000, 32'hff7f_ffff, 1'b0);
    send_frame(32'hffff_ffff, 32'h0000_00ff, 1'b1);
    send_frame(32'h0000_0000, 32'h0001_2345, 1'b0);

    // 8-bit slots, byte boundary around zero
    settle();
    write_reg(REG_SIXTEEN_BIT_MODE, '0);
    send_frame(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_frame(32'h0000_7f00, 32'hffff_ff00, 1'b0);

    // mono
    settle();
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(1));
    send_frame($urandom, $urandom, 1'b1);
    send_frame($urandom, $urandom, 1'b0);

    // zero channels acts as mono
    settle();
    write_reg(REG_CHANNEL_COUNT, '0);
    send_frame($urandom, $urandom, 1'b1);

    // widest frame, then an oversized count
    settle();
    write_reg(REG_SIXTEEN_BIT_MODE, CFG_DATA_W'(1));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(8));
    send_frame(32'h1234_5678, 32'hfedc_ba98, 1'b0);
    send_frame(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    settle();
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(15));
    send_frame($urandom, $urandom, 1'b1);

    // ring shrunk below the write position, then wrapping
    settle();
    write_reg(REG_RING_LENGTH, CFG_DATA_W'(3));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(2));
    send_frame($urandom, $urandom, 1'b0);
    send_frame($urandom, $urandom, 1'b1);

    // zero ring length acts as one slot
    settle();
    write_reg(REG_RING_LENGTH, '0);
    send_frame($urandom, $urandom, 1'b0);

    // oversized and full ring, unknown register ignored
    settle();
    write_reg(REG_RING_LENGTH, CFG_DATA_W'(17'h1ffff));
    send_frame($urandom, $urandom, 1'b1);
    settle();
    write_reg(REG_RING_LENGTH, MAX_RING_SLOTS);
    write_reg(REG_UNUSED, CFG_DATA_W'(17'h1ffff));
    send_frame($urandom, $urandom, 1'b0);

    // random phases, each with its own settings
    while (frames_sent < TOTAL_FRAMES) begin
      settle();
      pick_settings();
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(15, 40);
      if (phase_len > TOTAL_FRAMES - frames_sent) phase_len = TOTAL_FRAMES - frames_sent;
      repeat (phase_len) begin
        send_frame(draw_mix(), draw_mix(), 1'($urandom_range(0, 3) == 0));
      end
      calm = 1'b0;
    end

    // wrap up
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d frames under %0d register settings, %0d slots checked.",
             frames_sent, settings_used, slots_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d slots outstanding.", waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### mix_to_dma_sample_formatter.f
src/mtdsf_pkg.sv
src/mix_to_dma_sample_formatter.sv
tb/sv/mtdsf_slot_checker.sv
tb/sv/tb_top.sv
